>>> rtl/elx_pkg.sv
// Shared types, codes and character constants for the expression character lexer.
`default_nettype none

package elx_pkg;

    // Character constants used by the classifier.
    localparam logic [7:0] CharDot    = 8'h2E;
    localparam logic [7:0] CharSpace  = 8'h20;
    localparam logic [7:0] CharOpen   = 8'h28;
    localparam logic [7:0] CharClose  = 8'h29;
    localparam logic [7:0] CharUnder  = 8'h5F;
    localparam logic [7:0] CharPlus   = 8'h2B;
    localparam logic [7:0] CharMinus  = 8'h2D;

    // Result action codes.
    localparam logic [2:0] ActSpace   = 3'd0;
    localparam logic [2:0] ActBegin   = 3'd1;
    localparam logic [2:0] ActAppend  = 3'd2;
    localparam logic [2:0] ActError   = 3'd3;
    localparam logic [2:0] ActIgnored = 3'd4;

    // Token class codes.
    localparam logic [1:0] ClassNum   = 2'd0;
    localparam logic [1:0] ClassOp    = 2'd1;
    localparam logic [1:0] ClassId    = 2'd2;
    localparam logic [1:0] ClassParen = 2'd3;

    // Pending token mode, one-hot.
    typedef enum logic [3:0] {
        MODE_EMPTY = 4'b0001,
        MODE_NUM   = 4'b0010,
        MODE_OP    = 4'b0100,
        MODE_ID    = 4'b1000
    } lex_mode_t;

    // One input item.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0] action;
        logic [1:0] token_class;
        logic       closes_before;
        logic       retyped;
        logic       ends_at_last;
    } result_t;

    // Character class flags from the classifier.
    typedef struct packed {
        logic num;
        logic op;
        logic id;
        logic dot;
        logic space;
        logic open;
        logic close;
        logic sign;
    } char_class_t;

    // Token class of a non-empty pending mode.
    function automatic logic [1:0] mode_class(input lex_mode_t mode);
        logic [1:0] cls;
        case (mode)
            MODE_NUM: cls = ClassNum;
            MODE_OP:  cls = ClassOp;
            MODE_ID:  cls = ClassId;
            default:  cls = ClassNum;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> rtl/elx_char_class.sv
// Character classifier: sorts one byte into the lexer's character sets.
`default_nettype none

module elx_char_class (
    input  wire logic [7:0]          ch,
    output elx_pkg::char_class_t     cls
);
    import elx_pkg::*;

    // Digits and dot form numbers; letters and underscore form identifiers.
    always_comb
    begin
        cls.num   = (ch inside {[8'h30:8'h39]}) || (ch == CharDot);
        cls.op    = ch inside {8'h25, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h3C,
                               8'h3E, 8'h3D, 8'h26, 8'h7C, 8'h3A, 8'h2C};
        cls.id    = (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (ch == CharUnder);
        cls.dot   = (ch == CharDot);
        cls.space = (ch == CharSpace);
        cls.open  = (ch == CharOpen);
        cls.close = (ch == CharClose);
        cls.sign  = (ch == CharPlus) || (ch == CharMinus);
    end

endmodule

`default_nettype wire

>>> rtl/elx_lexer_fsm.sv
// Lexer state machine: holds the pending token state and forms one result per step.
`default_nettype none

module elx_lexer_fsm (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire elx_pkg::char_class_t cls,
    input  wire logic                 last,
    output elx_pkg::result_t          res
);
    import elx_pkg::*;

    lex_mode_t mode_reg, mode_next;
    logic      sign_only_reg, sign_only_next;
    logic      aos_reg, aos_next;
    logic      failed_reg, failed_next;
    logic      paren;
    logic      known;

    // Next state and result for the character in the input register.
    always_comb
    begin
        mode_next      = mode_reg;
        sign_only_next = sign_only_reg;
        aos_next       = aos_reg;
        failed_next    = failed_reg;
        res            = '0;
        res.action     = ActError;
        paren          = 1'b0;
        known          = cls.num || cls.op || cls.id;

        if (failed_reg)
        begin
            res.action = ActIgnored;
        end
        else if (cls.open || cls.close)
        begin
            res.closes_before = (mode_reg != MODE_EMPTY);
            res.action        = ActBegin;
            paren             = 1'b1;
            mode_next         = MODE_EMPTY;
            sign_only_next    = 1'b0;
            aos_next          = cls.open;
        end
        else if (cls.space)
        begin
            res.action = ActSpace;
            if (mode_reg != MODE_EMPTY)
            begin
                res.closes_before = 1'b1;
                aos_next          = 1'b0;
            end
            mode_next      = MODE_EMPTY;
            sign_only_next = 1'b0;
        end
        else if (!known)
        begin
            failed_next = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_EMPTY:
                begin
                    res.action     = ActBegin;
                    mode_next      = cls.num ? MODE_NUM : (cls.op ? MODE_OP : MODE_ID);
                    sign_only_next = cls.op && cls.sign;
                end
                MODE_NUM:
                begin
                    if (cls.num)
                    begin
                        res.action = ActAppend;
                    end
                    else
                    begin
                        res.action        = ActBegin;
                        res.closes_before = 1'b1;
                        aos_next          = 1'b0;
                        mode_next         = cls.op ? MODE_OP : MODE_ID;
                        sign_only_next    = cls.op && cls.sign;
                    end
                end
                MODE_OP:
                begin
                    if (cls.op)
                    begin
                        res.action     = ActAppend;
                        sign_only_next = 1'b0;
                    end
                    else if (sign_only_reg && aos_reg)
                    begin
                        // A lone leading sign joins the number or identifier.
                        res.action     = ActAppend;
                        res.retyped    = 1'b1;
                        mode_next      = cls.num ? MODE_NUM : MODE_ID;
                        sign_only_next = 1'b0;
                    end
                    else
                    begin
                        res.action        = ActBegin;
                        res.closes_before = 1'b1;
                        aos_next          = 1'b0;
                        mode_next         = cls.num ? MODE_NUM : MODE_ID;
                        sign_only_next    = 1'b0;
                    end
                end
                MODE_ID:
                begin
                    if (cls.id || (cls.num && !cls.dot))
                    begin
                        res.action = ActAppend;
                    end
                    else if (cls.op)
                    begin
                        res.action        = ActBegin;
                        res.closes_before = 1'b1;
                        aos_next          = 1'b0;
                        mode_next         = MODE_OP;
                        sign_only_next    = cls.sign;
                    end
                    else
                    begin
                        // A dot inside an identifier is an error.
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end

        // Class and end-of-expression completion for begun or extended tokens.
        if ((res.action == ActBegin) || (res.action == ActAppend))
        begin
            res.token_class  = paren ? ClassParen : mode_class(mode_next);
            res.ends_at_last = last && (mode_next != MODE_EMPTY);
        end

        // An error drops the pending token; nothing is pending afterward.
        if (failed_next && !failed_reg)
        begin
            mode_next      = MODE_EMPTY;
            sign_only_next = 1'b0;
        end
    end

    // State registers; the final character returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_EMPTY;
            sign_only_reg <= 1'b0;
            aos_reg       <= 1'b1;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (last)
            begin
                mode_reg      <= MODE_EMPTY;
                sign_only_reg <= 1'b0;
                aos_reg       <= 1'b1;
                failed_reg    <= 1'b0;
            end
            else
            begin
                mode_reg      <= mode_next;
                sign_only_reg <= sign_only_next;
                aos_reg       <= aos_next;
                failed_reg    <= failed_next;
            end
        end
    end

    // After an error nothing stays pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (mode_reg == MODE_EMPTY) && !sign_only_reg)
        else $error("pending token held after error");

    // A lone sign flag only makes sense for a pending operator.
    assert property (@(posedge clk) disable iff (!rst_n)
        sign_only_reg |-> (mode_reg == MODE_OP))
        else $error("sign flag set without pending operator");

    // The last character of an expression restores the reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (mode_reg == MODE_EMPTY) && aos_reg && !failed_reg
                           && !sign_only_reg)
        else $error("state not restored after last character");

    // Retyping needs a lone sign at the start or after an open parenthesis.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.retyped) |-> sign_only_reg && aos_reg)
        else $error("retype without leading sign");

endmodule

`default_nettype wire

>>> rtl/expression_char_lexer_core.sv
// Expression character lexer top level: input register, lexer step and result register.
//
// Usage:
// - The item channel (item_valid, item_stall, item) carries one character byte and a
//   last flag per transfer. The result channel (result_valid, result_stall, result)
//   returns exactly one result per character, in order.
// - A character accepted into the input register moves on into the result register, where
//   its result is offered; a stalled result register holds it in the input register.
// - Throughput: one character per cycle while the receiver does not stall. The lexer
//   state is updated in the same cycle that a character moves from the input register
//   into the result register.
// - When the receiver stalls, the result register holds its transfer; the input
//   register still takes one more character, after which item_stall rises. item_stall
//   follows result_stall combinationally in that case.
// - Reset (rst_n low) empties both registers and returns the lexer to its start state:
//   no token pending, start of expression, no error. A character flagged last also
//   returns the lexer to that state after its result is formed.
`default_nettype none

module expression_char_lexer_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire elx_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output elx_pkg::result_t      result
);
    import elx_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    logic        advance;
    char_class_t ch_cls;
    result_t     step_res;

    // Move the held character on whenever the result register is free or draining.
    assign advance      = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall   = in_valid_reg && !advance;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    elx_char_class u_char_class (
        .ch  (in_item_reg.ch),
        .cls (ch_cls)
    );

    elx_lexer_fsm u_lexer_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cls   (ch_cls),
        .last  (in_item_reg.last),
        .res   (step_res)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the expression character lexer core.

module testbench;
    import elx_pkg::*;

    // Tracks the lexer state for each accepted character and holds the marks still due.
    class lex_tracker;
        result_t   marks_due[$];
        lex_mode_t mode;
        bit        sign_only;
        bit        at_start;
        bit        failed;
        int        mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        // State at the start of every expression.
        function void restart();
            mode      = MODE_EMPTY;
            sign_only = 1'b0;
            at_start  = 1'b1;
            failed    = 1'b0;
        endfunction

        function bit is_operator(logic [7:0] c);
            case (c)
                "%", "+", "-", "*", "/", "^", "<", ">", "=", "&", "|", ":", ",": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Works out the marks for one character and advances the lexer state.
        function void note_char(logic [7:0] c, logic is_last);
            result_t mark;
            bit num;
            bit op;
            bit id;
            bit sign;
            num  = (c >= "0" && c <= "9") || c == CharDot;
            op   = is_operator(c);
            id   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CharUnder;
            sign = (c == CharPlus || c == CharMinus);
            mark = '0;
            mark.action = ActError;
            if (failed)
            begin
                mark.action = ActIgnored;
            end
            else if (c == CharOpen || c == CharClose)
            begin
                mark.closes_before = (mode != MODE_EMPTY);
                mark.action        = ActBegin;
                mark.token_class   = ClassParen;
                mode               = MODE_EMPTY;
                sign_only          = 1'b0;
                at_start           = (c == CharOpen);
            end
            else if (c == CharSpace)
            begin
                mark.action = ActSpace;
                if (mode != MODE_EMPTY)
                begin
                    mark.closes_before = 1'b1;
                    at_start           = 1'b0;
                end
                mode      = MODE_EMPTY;
                sign_only = 1'b0;
            end
            else if (!(num || op || id))
            begin
                failed = 1'b1;
            end
            else if (mode == MODE_EMPTY)
            begin
                mark.action = ActBegin;
                mode        = num ? MODE_NUM : (op ? MODE_OP : MODE_ID);
                sign_only   = op && sign;
            end
            else if (mode == MODE_NUM)
            begin
                if (num)
                begin
                    mark.action = ActAppend;
                end
                else
                begin
                    mark.action        = ActBegin;
                    mark.closes_before = 1'b1;
                    at_start           = 1'b0;
                    mode               = op ? MODE_OP : MODE_ID;
                    sign_only          = op && sign;
                end
            end
            else if (mode == MODE_OP)
            begin
                if (op)
                begin
                    mark.action = ActAppend;
                    sign_only   = 1'b0;
                end
                else if (sign_only && at_start)
                begin
                    // A lone leading sign joins the number or identifier that follows.
                    mark.action  = ActAppend;
                    mark.retyped = 1'b1;
                    mode         = num ? MODE_NUM : MODE_ID;
                    sign_only    = 1'b0;
                end
                else
                begin
                    mark.action        = ActBegin;
                    mark.closes_before = 1'b1;
                    at_start           = 1'b0;
                    mode               = num ? MODE_NUM : MODE_ID;
                    sign_only          = 1'b0;
                end
            end
            else
            begin
                // Identifier: digits continue it, a dot is an error.
                if (id || (num && c != CharDot))
                begin
                    mark.action = ActAppend;
                end
                else if (op)
                begin
                    mark.action        = ActBegin;
                    mark.closes_before = 1'b1;
                    at_start           = 1'b0;
                    mode               = MODE_OP;
                    sign_only          = sign;
                end
                else
                begin
                    failed = 1'b1;
                end
            end

            // Class of the token begun or extended, and completion on the last character.
            if ((mark.action == ActBegin || mark.action == ActAppend)
                    && mark.token_class != ClassParen)
            begin
                case (mode)
                    MODE_OP: mark.token_class = ClassOp;
                    MODE_ID: mark.token_class = ClassId;
                    default: mark.token_class = ClassNum;
                endcase
            end
            if ((mark.action == ActBegin || mark.action == ActAppend)
                    && is_last && mode != MODE_EMPTY)
            begin
                mark.ends_at_last = 1'b1;
            end

            if (is_last)
            begin
                restart();
            end
            marks_due.insert(marks_due.size(), mark);
        endfunction

        // Compares one result transfer with the oldest mark due.
        function void check_mark(result_t got);
            result_t want;
            if (marks_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = marks_due.pop_front();
            if (got.action !== want.action)
            begin
                $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
                mismatches++;
            end
            if (got.token_class !== want.token_class)
            begin
                $display("%0t: token_class expected %0d actual %0d",
                         $time, want.token_class, got.token_class);
                mismatches++;
            end
            if (got.closes_before !== want.closes_before)
            begin
                $display("%0t: closes_before expected %0d actual %0d",
                         $time, want.closes_before, got.closes_before);
                mismatches++;
            end
            if (got.retyped !== want.retyped)
            begin
                $display("%0t: retyped expected %0d actual %0d", $time, want.retyped, got.retyped);
                mismatches++;
            end
            if (got.ends_at_last !== want.ends_at_last)
            begin
                $display("%0t: ends_at_last expected %0d actual %0d",
                         $time, want.ends_at_last, got.ends_at_last);
                mismatches++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    lex_tracker tracker = new();
    int chars_sent = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    expression_char_lexer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock with a period of 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every result transfer is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            tracker.check_mark(result);
        end
    end

    // Receiver: random stalls, none in the steady stretch, and one long hold-off on request.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (60) @(negedge clk);
            end
            result_stall <= rst_n && !steady && ($urandom_range(99) < 30);
        end
    end

    // Offers one character at a falling edge and waits for its transfer.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while (!steady && $urandom_range(99) < 30)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{ch: c, last: is_last};
        @(posedge clk);
        while (item_stall) @(posedge clk);
        tracker.note_char(c, is_last);
        chars_sent++;
        @(negedge clk);
    endtask

    // Sends a whole expression, flagging its final character as last.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_digit();
        int k;
        k = $urandom_range(10);
        return (k == 10) ? CharDot : 8'("0" + k);
    endfunction

    function automatic logic [7:0] pick_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26) return 8'("a" + k);
        if (k < 52) return 8'("A" + k - 26);
        return CharUnder;
    endfunction

    function automatic logic [7:0] pick_operator();
        string ops;
        ops = "%+-*/^<>=&|:,";
        return ops[$urandom_range(ops.len() - 1)];
    endfunction

    // Builds a random expression from tokens, optionally with one stray byte.
    task automatic send_expr(input bit noisy);
        logic [7:0] text[$];
        int ntok;
        int kind;
        int n;
        bit lead;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++)
        begin
            kind = $urandom_range(5);
            lead = (text.size() == 0 || text[text.size() - 1] == CharOpen);
            if ((kind == 0 || kind == 1) && lead && $urandom_range(1))
            begin
                text.insert(text.size(), $urandom_range(1) ? CharPlus : CharMinus);
            end
            case (kind)
                0:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) text.insert(text.size(), pick_digit());
                end
                1:
                begin
                    text.insert(text.size(), pick_letter());
                    n = $urandom_range(3);
                    repeat (n)
                    begin
                        if ($urandom_range(11) == 0)
                            text.insert(text.size(), CharDot);
                        else if ($urandom_range(2) == 0)
                            text.insert(text.size(), 8'("0" + $urandom_range(9)));
                        else
                            text.insert(text.size(), pick_letter());
                    end
                end
                2:
                begin
                    n = $urandom_range(1, 2);
                    repeat (n) text.insert(text.size(), pick_operator());
                end
                3: text.insert(text.size(), CharOpen);
                4: text.insert(text.size(), CharClose);
                default: text.insert(text.size(), CharSpace);
            endcase
            if ($urandom_range(3) == 0) text.insert(text.size(), CharSpace);
        end
        if (noisy)
        begin
            text.insert($urandom_range(text.size()), 8'($urandom_range(255)));
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    // Stimulus: reset, directed expressions, then random ones.
    initial
    begin
        bit hold_done;
        hold_done  = 1'b0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Leading sign at the start joins an identifier; a space ends it.
        send_text("+a_9 ");
        // Dot inside an identifier, then bytes ignored through the last one.
        send_char("x", 1'b0);
        send_char(CharDot, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // Sign after an open parenthesis, operator run, number left pending at the end.
        send_text("(-3)*/7");
        // Error on the last character.
        send_text("1#");
        // A sign that is not leading starts an operator token of its own.
        send_text("a-b");
        send_text(")");
        send_text("9");

        // Random expressions, with a steady stretch and one long receiver hold-off.
        while (chars_sent < 1120)
        begin
            steady = (chars_sent >= 600 && chars_sent < 800);
            if (!hold_done && chars_sent >= 300)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_expr($urandom_range(99) < 15);
        end
        steady = 1'b0;
        item_valid <= 1'b0;

        // Drain the marks due, then let the pipeline settle.
        while (tracker.marks_due.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.marks_due.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/elx_pkg.sv
rtl/elx_char_class.sv
rtl/elx_lexer_fsm.sv
rtl/expression_char_lexer_core.sv
bench/testbench.sv
